// ===== design/mtcd_pkg.sv =====
// shared constants and types of the moving average trend cross detector
`default_nettype none

package mtcd_pkg;

   localparam int WINDOW      = 20;
   localparam int SAMPLE_BITS = 12;

   localparam int SAMPLE_IN_W = 12;
   localparam int SMP_W       = (SAMPLE_BITS < SAMPLE_IN_W) ? SAMPLE_BITS : SAMPLE_IN_W;
   localparam int SLOT_W      = $clog2(WINDOW);
   localparam int SUM_W       = $clog2(WINDOW * ((2 ** SMP_W) - 1) + 1);
   localparam int CFG_W       = 12;
   localparam int LIM_W       = CFG_W + 1 + $clog2(WINDOW + 1);
   localparam int CMP_W       = (LIM_W > SUM_W) ? LIM_W : SUM_W;
   localparam int SUM_OUT_W   = 17;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 24;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CFG_W-1:0] THRESHOLD_RESET = 12'd2600;
   localparam logic [CFG_W-1:0] MARGIN_RESET    = 12'd50;

   localparam logic [0:0] REG_THRESHOLD = 1'b0;
   localparam logic [0:0] REG_MARGIN    = 1'b1;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [SMP_W-1:0] oldest;
      logic             ready;
   } win_type;

   typedef struct packed {
      logic [CFG_W-1:0] threshold;
      logic [CFG_W-1:0] margin;
   } cfg_type;

endpackage

`default_nettype wire

// ===== design/mtcd_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module mtcd_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 20
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== design/mtcd_window.sv =====
// sample ring, running sum and fill tracking with oldest sample prefetch
`default_nettype none

module mtcd_window (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      accept,
   input  wire logic [mtcd_pkg::SMP_W-1:0] sample,
   input  wire logic                      advance,
   output logic                           stage_valid,
   output mtcd_pkg::win_type              stage
);

   logic [mtcd_pkg::SLOT_W-1:0] slot_ff, slot_in, slot_next;
   logic [mtcd_pkg::SLOT_W-1:0] fill_ff, fill_in;
   logic [mtcd_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic [mtcd_pkg::SMP_W-1:0]  oldest_ff, oldest_in;
   logic                        valid_ff, valid_in;
   logic [mtcd_pkg::SUM_W-1:0]  stage_sum_ff, stage_sum_in;
   logic                        stage_ready_ff, stage_ready_in;
   logic [mtcd_pkg::SMP_W-1:0]  rd_data;
   logic [mtcd_pkg::SMP_W-1:0]  stage_oldest;
   logic [mtcd_pkg::SMP_W-1:0]  old_val;
   logic                        ready_now;

   mtcd_ram #(
      .WIDTH (mtcd_pkg::SMP_W),
      .DEPTH (mtcd_pkg::WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (slot_ff),
      .wr_data (sample),
      .rd_en   (accept),
      .rd_addr (slot_next),
      .rd_data (rd_data)
   );

   always_comb begin
      slot_next    = (slot_ff == mtcd_pkg::SLOT_W'(mtcd_pkg::WINDOW - 1)) ? '0
                                                                         : slot_ff + 1'b1;
      ready_now    = (fill_ff == mtcd_pkg::SLOT_W'(mtcd_pkg::WINDOW - 1));
      // slots not yet written are read as zero until the window has filled
      stage_oldest = stage_ready_ff ? rd_data : '0;
      old_val      = valid_ff ? stage_oldest : oldest_ff;

      slot_in        = slot_ff;
      fill_in        = fill_ff;
      sum_in         = sum_ff;
      stage_sum_in   = stage_sum_ff;
      stage_ready_in = stage_ready_ff;
      oldest_in      = oldest_ff;
      valid_in       = valid_ff;

      if (advance) begin
         oldest_in = stage_oldest;
         valid_in  = 1'b0;
      end
      if (accept) begin
         slot_in        = slot_next;
         fill_in        = ready_now ? fill_ff : fill_ff + 1'b1;
         sum_in         = sum_ff - mtcd_pkg::SUM_W'(old_val) + mtcd_pkg::SUM_W'(sample);
         stage_sum_in   = sum_in;
         stage_ready_in = ready_now;
         valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff        <= '0;
         fill_ff        <= '0;
         sum_ff         <= '0;
         oldest_ff      <= '0;
         valid_ff       <= 1'b0;
         stage_ready_ff <= 1'b0;
      end else begin
         slot_ff        <= slot_in;
         fill_ff        <= fill_in;
         sum_ff         <= sum_in;
         oldest_ff      <= oldest_in;
         valid_ff       <= valid_in;
         stage_ready_ff <= stage_ready_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_sum_ff <= stage_sum_in;
   end

   assign stage_valid   = valid_ff;
   assign stage.sum     = stage_sum_ff;
   assign stage.oldest  = stage_oldest;
   assign stage.ready   = stage_ready_ff;

endmodule

`default_nettype wire

// ===== design/mtcd_decide.sv =====
// trend and hysteresis crossing decision with result register
`default_nettype none

module mtcd_decide (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                stage_valid,
   input  wire mtcd_pkg::win_type                   stage,
   input  wire mtcd_pkg::cfg_type                   cfg,
   input  wire logic                                rsp_tready,
   output logic                                     out_free,
   output logic                                     rsp_tvalid,
   output logic      [mtcd_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [mtcd_pkg::RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                              last_trend_ff, last_trend_in;
   logic                              indicator_ff, indicator_in;
   logic [mtcd_pkg::CMP_W-1:0]        sum_w, prod, hi_lim, lo_lim;
   logic                              lo_ok, trend, change, up_cross, down_cross;
   logic                              advance;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_tready;
      advance  = stage_valid && out_free;

      sum_w  = mtcd_pkg::CMP_W'(stage.sum);
      prod   = mtcd_pkg::CMP_W'(stage.oldest) * mtcd_pkg::CMP_W'(mtcd_pkg::WINDOW);
      hi_lim = (mtcd_pkg::CMP_W'(cfg.threshold) + mtcd_pkg::CMP_W'(cfg.margin))
               * mtcd_pkg::CMP_W'(mtcd_pkg::WINDOW);
      lo_ok  = cfg.threshold >= cfg.margin;
      lo_lim = mtcd_pkg::CMP_W'(cfg.threshold - cfg.margin)
               * mtcd_pkg::CMP_W'(mtcd_pkg::WINDOW);

      trend      = prod < sum_w;
      change     = stage.ready && (trend != last_trend_ff);
      up_cross   = change && trend && (sum_w > hi_lim);
      down_cross = change && !trend && lo_ok && (sum_w < lo_lim);

      last_trend_in = last_trend_ff;
      indicator_in  = indicator_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      if (out_free) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         if (change) begin
            last_trend_in = trend;
         end
         priority if (up_cross) begin
            indicator_in = 1'b0;
         end else if (down_cross) begin
            indicator_in = 1'b1;
         end
         rsp_valid_in = 1'b1;
         // window_sum, trend_up, up_cross, down_cross, indicator_level, window_ready
         rsp_data_in  = mtcd_pkg::RSP_DATA_W'({stage.ready, indicator_in, down_cross,
                                               up_cross, trend,
                                               mtcd_pkg::SUM_OUT_W'(stage.sum)});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         last_trend_ff <= 1'b0;
         indicator_ff  <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         last_trend_ff <= last_trend_in;
         indicator_ff  <= indicator_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== design/moving_average_trend_cross_detector_unit.sv =====
// top level of the moving average trend cross detector with register port
// throughput: one item per cycle while the result is not stalled, set by the
// ring ram with one write and one prefetch read per item, the oldest sample
// forwarded from the read stage
// reset: synchronous; clears sum, slot, fill count, trend and indicator and
// loads register defaults; unwritten ring slots read as zero by fill count
`default_nettype none

module moving_average_trend_cross_detector_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [mtcd_pkg::REQ_DATA_W-1:0]   req_tdata,   // sample
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // window_sum, trend_up, up_cross, down_cross, indicator_level, window_ready
   output logic      [mtcd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [mtcd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [mtcd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [mtcd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready
);

   logic [mtcd_pkg::CFG_W-1:0] threshold_ff, threshold_in;
   logic [mtcd_pkg::CFG_W-1:0] margin_ff, margin_in;
   logic [0:0]                 reg_index;
   logic                       csr_write;
   logic                       accept, advance, out_free, stage_valid;
   mtcd_pkg::win_type          stage;
   mtcd_pkg::cfg_type          cfg;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[2:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      threshold_in = threshold_ff;
      margin_in    = margin_ff;
      csr_prdata   = '0;
      if (csr_write) begin
         unique case (reg_index)
            mtcd_pkg::REG_THRESHOLD: threshold_in = csr_pwdata[mtcd_pkg::CFG_W-1:0];
            mtcd_pkg::REG_MARGIN:    margin_in    = csr_pwdata[mtcd_pkg::CFG_W-1:0];
            default:                 threshold_in = threshold_ff;
         endcase
      end
      unique case (reg_index)
         mtcd_pkg::REG_THRESHOLD: csr_prdata = mtcd_pkg::CSR_DATA_W'(threshold_ff);
         mtcd_pkg::REG_MARGIN:    csr_prdata = mtcd_pkg::CSR_DATA_W'(margin_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= mtcd_pkg::THRESHOLD_RESET;
         margin_ff    <= mtcd_pkg::MARGIN_RESET;
      end else begin
         threshold_ff <= threshold_in;
         margin_ff    <= margin_in;
      end
   end

   assign cfg.threshold = threshold_ff;
   assign cfg.margin    = margin_ff;

   assign req_tready = !stage_valid || out_free;
   assign accept     = req_tvalid && req_tready;
   assign advance    = stage_valid && out_free;

   mtcd_window u_window (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .sample      (req_tdata[mtcd_pkg::SMP_W-1:0]),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage       (stage)
   );

   mtcd_decide u_decide (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage       (stage),
      .cfg         (cfg),
      .rsp_tready  (rsp_tready),
      .out_free    (out_free),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== design/mtcd_checker.sv =====
// port level checks of the trend cross detector, bound to the top level
`default_nettype none

module mtcd_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic [mtcd_pkg::REQ_DATA_W-1:0]   req_tdata,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [mtcd_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   logic unused_in;
   assign unused_in = req_tvalid ^ req_tready ^ (^req_tdata);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_cross_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[18] && rsp_tdata[19]))
      else $error("cross up and cross down in one item");

   a_up_cross: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[18] |-> rsp_tdata[17] && rsp_tdata[21] && !rsp_tdata[20])
      else $error("cross up without up trend, warm window or low indicator");

   a_down_cross: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[19] |-> !rsp_tdata[17] && rsp_tdata[21] && rsp_tdata[20])
      else $error("cross down without down trend, warm window or high indicator");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind moving_average_trend_cross_detector_unit mtcd_checker u_mtcd_checker (.*);

`default_nettype wire

// ===== dv/trend_cross_checker.sv =====
`timescale 1ns / 100ps
// predicts and compares result items and register reads of the trend cross detector
module trend_cross_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   input  wire logic [mtcd_pkg::REQ_DATA_W-1:0] req_tdata,   // sample
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // window_sum, trend_up, up_cross, down_cross, indicator_level, window_ready
   input  wire logic [mtcd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [mtcd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [mtcd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  wire logic [mtcd_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  wire logic                            csr_pready,
   output int                                   mismatch_count,
   output int                                   expected_left
);

   typedef struct {
      logic [mtcd_pkg::SUM_OUT_W-1:0] window_sum;
      logic                           trend_up;
      logic                           up_cross;
      logic                           down_cross;
      logic                           indicator_level;
      logic                           window_ready;
   } result_type;

   result_type                 expected_results[$];
   result_type                 want;
   logic [11:0]                sample_ring[mtcd_pkg::WINDOW];
   int                         write_slot;
   int                         fill_count;
   int                         window_total;
   bit                         last_trend;
   bit                         indicator_state;
   logic [mtcd_pkg::CFG_W-1:0] threshold;
   logic [mtcd_pkg::CFG_W-1:0] margin;

   initial begin
      mismatch_count = 0;
      expected_left  = 0;
   end

   function automatic result_type predict_trend_cross(input logic [11:0] smp);
      result_type r;
      int         upper_limit;
      int         lower_limit;
      bit         ready_now;
      bit         trend_now;
      ready_now    = fill_count >= mtcd_pkg::WINDOW - 1;
      window_total = window_total - int'(sample_ring[write_slot]) + int'(smp);
      sample_ring[write_slot] = smp;
      write_slot   = (write_slot + 1) % mtcd_pkg::WINDOW;
      if (!ready_now) fill_count++;
      // oldest sample is the slot the next item overwrites
      trend_now    = int'(sample_ring[write_slot]) * mtcd_pkg::WINDOW < window_total;
      r.up_cross   = 1'b0;
      r.down_cross = 1'b0;
      if (ready_now && trend_now != last_trend) begin
         upper_limit = (int'(threshold) + int'(margin)) * mtcd_pkg::WINDOW;
         lower_limit = (int'(threshold) - int'(margin)) * mtcd_pkg::WINDOW;
         if (trend_now && window_total > upper_limit) begin
            r.up_cross      = 1'b1;
            indicator_state = 1'b0;
         end else if (!trend_now && window_total < lower_limit) begin
            r.down_cross    = 1'b1;
            indicator_state = 1'b1;
         end
         last_trend = trend_now;
      end
      r.window_sum      = mtcd_pkg::SUM_OUT_W'(window_total);
      r.trend_up        = trend_now;
      r.indicator_level = indicator_state;
      r.window_ready    = ready_now;
      return r;
   endfunction

   task automatic check_field(input string field, input int unsigned exp_val,
                              input int unsigned act_val);
      if (exp_val != act_val) begin
         mismatch_count++;
         $display("%0t: %s expected %0d actual %0d", $time, field, exp_val, act_val);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (sample_ring[i]) sample_ring[i] = '0;
         write_slot      = 0;
         fill_count      = 0;
         window_total    = 0;
         last_trend      = 1'b0;
         indicator_state = 1'b0;
         threshold       = mtcd_pkg::THRESHOLD_RESET;
         margin          = mtcd_pkg::MARGIN_RESET;
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               $display("%0t: result item expected none actual %h", $time, rsp_tdata);
            end else begin
               want = expected_results.pop_front();
               check_field("window_sum", want.window_sum, rsp_tdata[16:0]);
               check_field("trend_up", want.trend_up, rsp_tdata[17]);
               check_field("up_cross", want.up_cross, rsp_tdata[18]);
               check_field("down_cross", want.down_cross, rsp_tdata[19]);
               check_field("indicator_level", want.indicator_level, rsp_tdata[20]);
               check_field("window_ready", want.window_ready, rsp_tdata[21]);
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(predict_trend_cross(req_tdata[11:0]));
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr[2])
                  mtcd_pkg::REG_THRESHOLD: threshold = csr_pwdata[mtcd_pkg::CFG_W-1:0];
                  mtcd_pkg::REG_MARGIN:    margin    = csr_pwdata[mtcd_pkg::CFG_W-1:0];
               endcase
            end else begin
               check_field("register read",
                           (csr_paddr[2] == mtcd_pkg::REG_MARGIN) ? margin : threshold,
                           csr_prdata);
            end
         end
      end
      expected_left = expected_results.size();
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// testbench top that drives the trend cross detector and reports the verdict
module tb_top;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [mtcd_pkg::REQ_DATA_W-1:0] req_tdata;   // sample
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   // window_sum, trend_up, up_cross, down_cross, indicator_level, window_ready
   logic [mtcd_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [mtcd_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [mtcd_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [mtcd_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;
   int                              mismatch_count;
   int                              expected_left;

   bit                              quiet = 1'b0;
   bit                              hold_rsp = 1'b0;
   int                              seg_left = 0;
   int                              seg_level;
   int                              seg_amp;
   int                              seg_step;
   bit                              seg_ramp;

   moving_average_trend_cross_detector_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   trend_cross_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .expected_left  (expected_left)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic send_sample(input logic [11:0] smp);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= mtcd_pkg::REQ_DATA_W'(smp);
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic csr_access(input bit wr, input logic [0:0] idx,
                             input logic [mtcd_pkg::CFG_W-1:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= mtcd_pkg::CSR_DATA_W'(val);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic settle();
      @(posedge clock);
      wait (expected_left == 0);
      repeat (4) @(posedge clock);
   endtask

   // segments of steady levels and ramps with noise, plus full range noise
   task automatic next_waveform_sample(output logic [11:0] smp);
      int v;
      if (seg_left == 0) begin
         seg_left  = $urandom_range(4, 40);
         seg_level = $urandom_range(0, 4095);
         seg_amp   = $urandom_range(0, 1200);
         seg_ramp  = $urandom_range(0, 1);
         seg_step  = int'($urandom_range(0, 400)) - 200;
      end
      seg_left--;
      if (seg_ramp) seg_level += seg_step;
      if (seg_level < 0) seg_level = 0;
      if (seg_level > 4095) seg_level = 4095;
      v = seg_level + int'($urandom_range(0, 2 * seg_amp)) - seg_amp;
      if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 4095);
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      smp = v[11:0];
   endtask

   initial begin
      int          hold_cycles;
      int          burst;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            for (hold_cycles = 0; hold_cycles < 80; hold_cycles++) @(posedge clock);
            hold_rsp = 1'b0;
            rsp_tready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 4);
            rsp_tready <= 1'b0;
            repeat (burst) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      logic [11:0]                smp;
      logic [mtcd_pkg::CFG_W-1:0] thr;
      logic [mtcd_pkg::CFG_W-1:0] mar;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      reset       <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_access(1'b0, mtcd_pkg::REG_THRESHOLD, '0);
      csr_access(1'b0, mtcd_pkg::REG_MARGIN, '0);

      // warm-up at full scale, then a fall and rise around the default level
      repeat (8) send_sample(12'hFFF);
      repeat (8) send_sample(12'h000);
      send_sample(12'd2600);
      send_sample(12'd2650);
      send_sample(12'd2550);
      send_sample(12'd1);
      send_sample(12'hFFE);
      req_tvalid <= 1'b0;

      for (int phase = 0; phase < 6; phase++) begin
         settle();
         case (phase)
            0: begin thr = 12'd0;    mar = 12'd0;    end
            1: begin thr = 12'hFFF;  mar = 12'hFFF;  end
            2: begin thr = 12'd2048; mar = 12'd0;    end
            3: begin thr = 12'd300;  mar = 12'd1000; end
            4: begin
               thr = mtcd_pkg::CFG_W'($urandom_range(500, 3500));
               mar = mtcd_pkg::CFG_W'($urandom_range(0, 300));
            end
            default: begin thr = mtcd_pkg::THRESHOLD_RESET; mar = mtcd_pkg::MARGIN_RESET; end
         endcase
         csr_access(1'b1, mtcd_pkg::REG_THRESHOLD, thr);
         csr_access(1'b1, mtcd_pkg::REG_MARGIN, mar);
         csr_access(1'b0, mtcd_pkg::REG_THRESHOLD, '0);
         csr_access(1'b0, mtcd_pkg::REG_MARGIN, '0);
         for (int n = 0; n < 135; n++) begin
            if (phase == 1 && n == 30) hold_rsp = 1'b1;
            if (phase == 2 && n == 40) begin
               req_tvalid <= 1'b0;
               @(posedge clock);
               wait (expected_left == 0);
               @(posedge clock);
            end
            if (phase == 5 && n == 35) quiet = 1'b1;
            next_waveform_sample(smp);
            send_sample(smp);
         end
         req_tvalid <= 1'b0;
      end

      settle();
      repeat (6) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #1000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
